@@ src/lsbcbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcbp_pkg
// Shared types and constants of the LSB-first code bit packer.
// ----------------------------------------------------------------------------
package lsbcbp_pkg;

  // Field widths of the request and byte transactions.
  localparam int CODE_W = 64;
  localparam int LEN_W  = 7;
  localparam int SHIFT_W = $clog2(CODE_W);
  localparam int BYTE_W = 8;

  // Pending partial byte: up to seven bits and a three bit count.
  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;

  // Request type codes.
  localparam logic REQ_CODE  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Request transaction.
  typedef struct packed {
    logic              req_type;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
  } req_item_t;

  // Byte transaction.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              padded_final;
  } byte_item_t;

endpackage

@@ src/lsbcbp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcbp_front
// Accepts requests, merges code bits with the pending partial byte and
// hands the completed bytes of each request to the queue as one entry.
// ----------------------------------------------------------------------------
module lsbcbp_front #(
  parameter int MAX_CODE_BITS = 64,
  parameter int DATA_W        = 64,
  parameter int CNT_W         = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  lsbcbp_pkg::req_item_t req_data,
  output logic                  q_push,
  output logic [DATA_W+CNT_W:0] q_entry,
  input  logic                  q_full
);
  import lsbcbp_pkg::*;

  localparam int COMB_W = MAX_CODE_BITS + PEND_W;

  logic [PEND_W-1:0]        pend_bits;
  logic [PCNT_W-1:0]        pend_cnt;
  logic [PEND_W-1:0]        pend_bits_next;
  logic [PCNT_W-1:0]        pend_cnt_next;
  logic                     accept;
  logic [LEN_W-1:0]         len_sat;
  logic [CODE_W-1:0]        mask;
  logic [MAX_CODE_BITS-1:0] code_use;
  logic [COMB_W-1:0]        combined;
  logic [COMB_W-1:0]        shifted;
  logic [LEN_W-1:0]         total;
  logic [LEN_W-4:0]         nbytes;

  // The queue having no room holds off new requests.
  assign req_stall = q_full;
  assign accept    = req_valid && !req_stall;

  // Merge the masked code above the pending bits and split off whole bytes.
  always_comb begin
    if (req_data.code_len > LEN_W'(MAX_CODE_BITS)) begin
      len_sat = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = req_data.code_len;
    end
    if (len_sat >= LEN_W'(CODE_W)) begin
      mask = '1;
    end else begin
      mask = (CODE_W'(1) << len_sat[SHIFT_W-1:0]) - CODE_W'(1);
    end
    code_use = MAX_CODE_BITS'(req_data.code_bits & mask);
    combined = (COMB_W'(code_use) << pend_cnt) | COMB_W'(pend_bits);
    total    = LEN_W'(pend_cnt) + len_sat;
    nbytes   = total[LEN_W-1:3];
    shifted  = combined >> {nbytes, 3'b000};
  end

  // Build the queue entry and the next pending state.
  always_comb begin
    if (req_data.req_type == REQ_FLUSH) begin
      q_push         = accept && (pend_cnt != '0);
      q_entry        = {DATA_W'(pend_bits), CNT_W'(1), 1'b1};
      pend_bits_next = '0;
      pend_cnt_next  = '0;
    end else begin
      q_push         = accept && (nbytes != '0);
      q_entry        = {combined[DATA_W-1:0], CNT_W'(nbytes), 1'b0};
      pend_bits_next = shifted[PEND_W-1:0];
      pend_cnt_next  = total[PCNT_W-1:0];
    end
  end

  // Pending partial byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else if (accept) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

endmodule

@@ src/lsbcbp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcbp_queue
// Two-entry queue that decouples the request side from the byte side.
// ----------------------------------------------------------------------------
module lsbcbp_queue #(
  parameter int WIDTH = 69
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_entry,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_entry
);
  import lsbcbp_pkg::*;

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ src/lsbcbp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcbp_back
// Takes queue entries and sends their bytes out one per cycle through an
// output register while not stalled, marking the last byte of each request.
// ----------------------------------------------------------------------------
module lsbcbp_back #(
  parameter int DATA_W = 64,
  parameter int CNT_W  = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [DATA_W+CNT_W:0]  q_entry,
  output logic                   q_pop,
  output logic                   byte_valid,
  input  logic                   byte_stall,
  output lsbcbp_pkg::byte_item_t byte_data
);
  import lsbcbp_pkg::*;

  logic              work_valid;
  logic [DATA_W-1:0] work_data;
  logic [CNT_W-1:0]  work_left;
  logic              work_pad;
  logic              out_load;
  logic              work_done;

  // Move a byte when the output register is empty or being drained.
  always_comb begin
    out_load  = work_valid && (!byte_valid || !byte_stall);
    work_done = out_load && (work_left == CNT_W'(1));
    q_pop     = q_valid && (!work_valid || work_done);
  end

  // Control: output valid and working entry valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      work_valid <= 1'b0;
    end else begin
      if (out_load) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
      if (q_pop) begin
        work_valid <= 1'b1;
      end else if (work_done) begin
        work_valid <= 1'b0;
      end
    end
  end

  // Payload: output byte and the shifting working entry.
  always_ff @(posedge clk) begin
    if (out_load) begin
      byte_data.out_byte     <= work_data[BYTE_W-1:0];
      byte_data.last_of_run  <= (work_left == CNT_W'(1));
      byte_data.padded_final <= work_pad;
    end
    if (q_pop) begin
      work_data <= q_entry[DATA_W+CNT_W:CNT_W+1];
      work_left <= q_entry[CNT_W:1];
      work_pad  <= q_entry[0];
    end else if (out_load) begin
      work_data <= work_data >> BYTE_W;
      work_left <= work_left - CNT_W'(1);
    end
  end

endmodule

@@ src/lsb_first_code_bit_packer_core.sv @@
`timescale 1ns / 1ps
// The first byte of a request passes the queue, the working entry and the output register.
// Throughput: one byte per cycle at the output register while byte_stall is low; a
// request produces 0 to 8 bytes.
// Requests enter back to back while the two-entry queue has room.
// Reset clears the pending partial byte, the queue and the output register.
// ----------------------------------------------------------------------------
// lsb_first_code_bit_packer_core
// Packs variable-length codes into bytes, least significant bit first, with
// a flush request that emits the zero-padded partial byte.
// ----------------------------------------------------------------------------
module lsb_first_code_bit_packer_core #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  lsbcbp_pkg::req_item_t  req_data,
  output logic                   byte_valid,
  input  logic                   byte_stall,
  output lsbcbp_pkg::byte_item_t byte_data
);
  import lsbcbp_pkg::*;

  localparam int MAX_BYTES = (MAX_CODE_BITS + PEND_W) / BYTE_W;
  localparam int DATA_W    = MAX_BYTES * BYTE_W;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int ENTRY_W   = DATA_W + CNT_W + 1;

  logic               q_push;
  logic [ENTRY_W-1:0] q_push_entry;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_pop_entry;

  // Request side.
  lsbcbp_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .DATA_W       (DATA_W),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .q_push   (q_push),
    .q_entry  (q_push_entry),
    .q_full   (q_full)
  );

  // Decoupling queue.
  lsbcbp_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_entry (q_pop_entry)
  );

  // Byte side.
  lsbcbp_back #(
    .DATA_W(DATA_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_pop_entry),
    .q_pop     (q_pop),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data)
  );

  // The front end never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  // The back end only takes an entry that is present.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue read while empty");

  // A padded flush byte is always the last byte of its transaction.
  assert property (@(posedge clk) disable iff (rst)
    (byte_valid && byte_data.padded_final) |-> byte_data.last_of_run)
    else $error("padded byte not marked last");

endmodule

@@ bench/lsbcbp_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbcbp_stream_checker
// Watches the request and byte channels of the code bit packer. It keeps its
// own copy of the pending partial byte and builds the bytes that each
// accepted request must produce. Each accepted byte transaction is then
// compared field by field with the oldest predicted byte.
// ----------------------------------------------------------------------------
module lsbcbp_stream_checker #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_stall,
  input  lsbcbp_pkg::req_item_t  req_data,
  input  logic                   byte_valid,
  input  logic                   byte_stall,
  input  lsbcbp_pkg::byte_item_t byte_data,
  output int                     fail_count,
  output int                     bytes_outstanding
);

  import lsbcbp_pkg::*;

  // Mirror of the packer state: pending bits, earliest in bit 0, and their count.
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;
  byte_item_t        predicted_bytes[$];
  int                mismatches = 0;

  initial begin
    fail_count = 0;
    bytes_outstanding = 0;
    pend_bits = '0;
    pend_cnt = '0;
  end

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Work out the bytes one request transaction causes and update the mirror.
  task automatic pack_request(input req_item_t req);
    logic [BYTE_W-1:0] acc;
    byte_item_t        entry;
    byte_item_t        staged[8];
    int                fill;
    int                len;
    int                n;
    acc = {1'b0, pend_bits};
    fill = int'(pend_cnt);
    n = 0;
    if (req.req_type == REQ_FLUSH) begin
      // Only a partial byte is emitted, with its unused high bits zero.
      if (fill != 0) begin
        entry.out_byte = acc & ((8'd1 << fill) - 8'd1);
        entry.last_of_run = 1'b1;
        entry.padded_final = 1'b1;
        predicted_bytes.push_back(entry);
      end
      pend_bits = '0;
      pend_cnt = '0;
    end else begin
      // Overlong lengths saturate; bits at and above the length are dropped.
      len = (req.code_len > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(req.code_len);
      for (int i = 0; i < len; i++) begin
        acc[fill] = req.code_bits[i];
        fill++;
        if (fill == BYTE_W) begin
          staged[n].out_byte = acc;
          staged[n].last_of_run = 1'b0;
          staged[n].padded_final = 1'b0;
          n++;
          acc = '0;
          fill = 0;
        end
      end
      for (int k = 0; k < n; k++) begin
        entry = staged[k];
        entry.last_of_run = (k == n - 1);
        predicted_bytes.push_back(entry);
      end
      pend_bits = acc[PEND_W-1:0];
      pend_cnt = fill[PCNT_W-1:0];
    end
  endtask

  // Predict on accepted requests, then compare accepted bytes.
  always @(posedge clk) begin
    if (rst) begin
      pend_bits = '0;
      pend_cnt = '0;
      predicted_bytes.delete();
    end else begin
      if (req_valid && !req_stall) begin
        pack_request(req_data);
      end
      if (byte_valid && !byte_stall) begin
        if (predicted_bytes.size() == 0) begin
          report_mismatch("unexpected byte", int'(byte_data.out_byte), 0);
        end else begin
          if (byte_data.out_byte !== predicted_bytes[0].out_byte) begin
            report_mismatch("out_byte", int'(byte_data.out_byte),
                            int'(predicted_bytes[0].out_byte));
          end
          if (byte_data.last_of_run !== predicted_bytes[0].last_of_run) begin
            report_mismatch("last_of_run", int'(byte_data.last_of_run),
                            int'(predicted_bytes[0].last_of_run));
          end
          if (byte_data.padded_final !== predicted_bytes[0].padded_final) begin
            report_mismatch("padded_final", int'(byte_data.padded_final),
                            int'(predicted_bytes[0].padded_final));
          end
          void'(predicted_bytes.pop_front());
        end
      end
    end
    fail_count <= mismatches;
    bytes_outstanding <= predicted_bytes.size();
  end

endmodule

@@ bench/tb_lsb_first_code_bit_packer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_first_code_bit_packer_core
// Drives code and flush requests into the packer: a directed set of edge
// cases, then random requests under several sender and receiver idling
// patterns, including one long receiver hold-off that backs up the input.
// The stream checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_lsb_first_code_bit_packer_core;

  import lsbcbp_pkg::*;

  localparam int MAX_CODE_BITS = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLDOFF_LEN   = 300;

  logic       clk;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_item_t  req_data = '0;
  logic       byte_valid;
  logic       byte_stall = 1'b0;
  byte_item_t byte_data;

  int fail_count;
  int bytes_outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_on = 1'b0;
  bit holdoff_used = 1'b0;
  int holdoff_left = 0;
  int cycle_count = 0;

  lsb_first_code_bit_packer_core #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data)
  );

  lsbcbp_stream_checker #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) checker_i (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req_data         (req_data),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .byte_data        (byte_data),
    .fail_count       (fail_count),
    .bytes_outstanding(bytes_outstanding)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off once pressure is requested.
  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
    end else if (pressure_on && !holdoff_used) begin
      holdoff_used <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
      byte_stall <= 1'b1;
    end else if (holdoff_left > 1) begin
      holdoff_left <= holdoff_left - 1;
      byte_stall <= 1'b1;
    end else begin
      holdoff_left <= 0;
      byte_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one request transaction, with a random idle gap first, and hold it
  // until it is accepted. Valid stays high into the next request.
  task automatic send_request(input req_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= item;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_code(input int len, input logic [CODE_W-1:0] bits);
    req_item_t item;
    item.req_type = REQ_CODE;
    item.code_bits = bits;
    item.code_len = len[LEN_W-1:0];
    send_request(item);
  endtask

  // The ignored fields of a flush carry random content.
  task automatic send_flush();
    req_item_t item;
    item.req_type = REQ_FLUSH;
    item.code_bits = {$urandom, $urandom};
    item.code_len = LEN_W'($urandom_range(127));
    send_request(item);
  endtask

  // Short codes most often, then long ones, some overlong ones, empty codes and flushes.
  task automatic send_random_request();
    int pick;
    logic [CODE_W-1:0] bits;
    pick = $urandom_range(99);
    bits = {$urandom, $urandom};
    if (pick < 10) begin
      send_flush();
    end else if (pick < 14) begin
      send_code(0, bits);
    end else if (pick < 60) begin
      send_code($urandom_range(1, 12), bits);
    end else if (pick < 92) begin
      send_code($urandom_range(13, 64), bits);
    end else begin
      send_code($urandom_range(65, 127), bits);
    end
  endtask

  task automatic send_random_batch(input int count);
    for (int i = 0; i < count; i++) begin
      send_random_request();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed edge cases, no idling.
    send_flush();                                    // flush with nothing pending
    send_code(0, {CODE_W{1'b1}});                    // empty code
    send_code(1, 64'h1);
    send_flush();                                    // one padded bit
    send_code(7, {CODE_W{1'b1}});
    send_code(1, 64'h0);                             // completes a byte
    send_code(8, 64'hFFFF_FFFF_FFFF_FFA5);           // stray high bits
    send_code(3, 64'h5);
    send_flush();
    send_code(64, {CODE_W{1'b1}});
    send_code(64, {$urandom, $urandom});
    send_code(5, 64'h15);
    send_code(64, 64'h0123_4567_89AB_CDEF);          // eight bytes, five left over
    send_code(65, {CODE_W{1'b1}});                   // overlong length
    send_code(127, 64'hDEAD_BEEF_0F0F_F0F0);         // all length bits set
    send_flush();
    send_code(63, 64'h0);
    send_code(1, 64'h1);
    send_code(100, 64'h0);
    send_flush();
    send_code(7, 64'h55);
    send_flush();
    send_flush();

    // Random traffic, no idling.
    send_random_batch(95);

    // Long receiver hold-off while the sender keeps offering.
    pressure_on <= 1'b1;
    send_random_batch(30);

    // Sender idle most of the time.
    send_idle_pct = 67;
    send_random_batch(95);

    // Receiver stalling most of the time.
    send_idle_pct = 0;
    recv_stall_pct <= 67;
    send_random_batch(95);

    // Light idling on both sides.
    send_idle_pct = 11;
    recv_stall_pct <= 11;
    send_random_batch(95);

    req_valid <= 1'b0;
    recv_stall_pct <= 0;

    // Wait for every predicted byte, then watch for stray output.
    repeat (2) @(posedge clk);
    while (bytes_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
